/* src/bpa_pkg.sv */
// Shared constants and codes for the bitmap page allocator.
package bpa_pkg;

    localparam int PAGES_PER_BLOCK_DEF = 512;
    localparam int WORD_BITS_DEF       = 64;

    localparam int OP_W     = 2;
    localparam int PIDX_W   = 9;
    localparam int BLOCK_W  = 23;
    localparam int PNUM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 10;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_BUSY = 2'd3;

endpackage

/* src/bpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bitmap_page_allocator_unit.sv */
// Bitmap page allocator: occupancy bitmap in RAM, next-fit word scan.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  request  | s_operation, s_page_index               | s_valid / s_ready
//  result   | m_page_number, m_status, m_free_pages,  | m_valid / m_ready
//           | m_block_full, m_block_empty             |
//  config   | cfg_wdata (block number)                | cfg_we, no wait
//
//  Allocate: the scan reads words from the start word on until one has a clear
//  bit, at most NUM_WORDS words; the bitmap RAM is read one word per cycle.
//  Free / mark busy: read, then check and write back, then result. Full block or
//  unknown op: straight to the result. One request at a time; a pending result
//  may wait in the output register while the next request is taken.
//  Reset: per-word valid bits clear at once, no clearing sweep.
module bitmap_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int PAGES_PER_BLOCK = PAGES_PER_BLOCK_DEF,
    parameter int WORD_BITS       = WORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [BLOCK_W-1:0]  cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [PIDX_W-1:0]   s_page_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [PNUM_W-1:0]   m_page_number,
    output logic [STATUS_W-1:0] m_status,
    output logic [FREE_W-1:0]   m_free_pages,
    output logic                m_block_full,
    output logic                m_block_empty
);

    // Both parameters must be powers of two; the block itself does not check this.
    localparam int NUM_WORDS = PAGES_PER_BLOCK / WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int PAGE_W    = $clog2(PAGES_PER_BLOCK);
    localparam int CNT_W     = $clog2(PAGES_PER_BLOCK + 1);
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(PAGES_PER_BLOCK);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_POST  = 2'd3;

    function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] b;
        logic             hit;
        b   = '0;
        hit = 1'b0;
        for (int k = 0; k < WORD_BITS; k++) begin
            if (!hit && !w[k]) begin
                b   = BIT_W'(k);
                hit = 1'b1;
            end
        end
        return b;
    endfunction

    logic [1:0]           state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [ADDR_W-1:0]    word_idx_reg, word_idx_next;
    logic [BIT_W-1:0]     bit_idx_reg, bit_idx_next;
    logic [ADDR_W-1:0]    start_word_reg, start_word_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [BLOCK_W-1:0]   block_reg;
    logic [PNUM_W-1:0]    res_page_reg, res_page_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [NUM_WORDS-1:0] word_valid_reg, word_valid_next;
    logic                 rd_valid_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [PNUM_W-1:0]    m_page_number_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [FREE_W-1:0]    m_free_pages_reg;
    logic                 m_block_full_reg;
    logic                 m_block_empty_reg;
    logic                 load_out;

    logic [PAGE_W-1:0]    page_in;
    logic [ADDR_W-1:0]    widx_in;
    logic [BIT_W-1:0]     bit_in;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] word_data;
    logic [WORD_BITS-1:0] bit_mask;
    logic [BIT_W-1:0]     clear_bit;
    logic [PAGE_W-1:0]    alloc_idx;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    assign page_in   = PAGE_W'(s_page_index);
    assign widx_in   = ADDR_W'(page_in >> BIT_W);
    assign bit_in    = page_in[BIT_W-1:0];
    assign word_data = rd_valid_reg ? rd_data : '0;
    assign bit_mask  = WORD_BITS'(1) << bit_idx_reg;
    assign clear_bit = lowest_clear(word_data);
    assign alloc_idx = (PAGE_W'(word_idx_reg) << BIT_W) | PAGE_W'(clear_bit);

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (word_idx_reg),
        .wr_data (wr_data),
        .rd_addr (word_idx_next),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        word_idx_next   = word_idx_reg;
        bit_idx_next    = bit_idx_reg;
        start_word_next = start_word_reg;
        count_next      = count_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        word_valid_next = word_valid_reg;
        wr_en           = 1'b0;
        wr_data         = word_data;
        load_out        = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_operation;
                    bit_idx_next    = bit_in;
                    res_page_next   = '0;
                    res_status_next = ST_OK;
                    word_idx_next   = (s_operation == OP_ALLOC) ? start_word_reg : widx_in;
                    case (s_operation) inside
                        OP_ALLOC: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_NO_FREE;
                                state_next      = S_POST;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_FREE, OP_MARK: state_next = S_CHECK;
                        default:          state_next = S_POST;
                    endcase
                end
            end
            S_SCAN: begin
                if (word_data != '1) begin
                    wr_en           = 1'b1;
                    wr_data         = word_data | (WORD_BITS'(1) << clear_bit);
                    start_word_next = word_idx_reg;
                    count_next      = count_reg - 1'b1;
                    res_page_next   = PNUM_W'({block_reg, alloc_idx});
                    state_next      = S_POST;
                end else begin
                    word_idx_next = (word_idx_reg == LAST_WORD) ? '0 : word_idx_reg + 1'b1;
                end
            end
            S_CHECK: begin
                state_next = S_POST;
                if (op_reg == OP_FREE) begin
                    if ((word_data & bit_mask) == '0) begin
                        res_status_next = ST_ALREADY_FREE;
                    end else begin
                        wr_en           = 1'b1;
                        wr_data         = word_data & ~bit_mask;
                        start_word_next = word_idx_reg;
                        count_next      = count_reg + 1'b1;
                    end
                end else begin
                    if ((word_data & bit_mask) != '0) begin
                        res_status_next = ST_ALREADY_BUSY;
                    end else begin
                        wr_en      = 1'b1;
                        wr_data    = word_data | bit_mask;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            S_POST: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (wr_en) begin
            word_valid_next[word_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            start_word_reg <= '0;
            count_reg      <= CNT_FULL;
            block_reg      <= '0;
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            start_word_reg <= start_word_next;
            count_reg      <= count_next;
            word_valid_reg <= word_valid_next;
            rd_valid_reg   <= word_valid_next[word_idx_next] && word_valid_reg[word_idx_next];
            m_valid_reg    <= m_valid_next;
            if (cfg_we) begin
                block_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        word_idx_reg   <= word_idx_next;
        bit_idx_reg    <= bit_idx_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        if (load_out) begin
            m_page_number_reg <= res_page_reg;
            m_status_reg      <= res_status_reg;
            m_free_pages_reg  <= FREE_W'(count_reg);
            m_block_full_reg  <= (count_reg == '0);
            m_block_empty_reg <= (count_reg == CNT_FULL);
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_page_number = m_page_number_reg;
    assign m_status      = m_status_reg;
    assign m_free_pages  = m_free_pages_reg;
    assign m_block_full  = m_block_full_reg;
    assign m_block_empty = m_block_empty_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("free count beyond block size");

    a_scan_has_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> count_reg != '0)
        else $error("scan entered with no free page");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in flight");

    a_no_free_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NO_FREE |-> m_block_full && m_page_number == '0)
        else $error("failed allocate without full block");

    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_block_full && m_block_empty))
        else $error("block both full and empty");

endmodule
